FILE: rtl/rtt_pkg.sv
// shared types, codes and defaults for the reloading timer slot table
// no dependencies; used by every module of the block
package rtt_pkg;

   // default sizing of the slot table
   localparam int DEFAULT_SLOTS      = 8;
   localparam int DEFAULT_COUNT_BITS = 16;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request op codes as they arrive on req_op
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_REG   = 2'd1;
   localparam logic [1:0] OP_UNREG = 2'd2;

   // result kind codes
   localparam logic [1:0] KIND_REGISTERED   = 2'd0;
   localparam logic [1:0] KIND_FULL         = 2'd1;
   localparam logic [1:0] KIND_UNREGISTERED = 2'd2;
   localparam logic [1:0] KIND_EXPIRED      = 2'd3;

   // decoded command carried through the queue
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_REG,
      CMD_UNREG
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [2:0] slot;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      EX_IDLE,
      EX_TICK,
      EX_FLUSH,
      EX_REG,
      EX_UNREG
   } exec_state_type;

endpackage

FILE: rtl/rtt_front.sv
// front end: takes request beats, decodes the op and saturates the counts
// depends on rtt_pkg; feeds rtt_queue
module rtt_front #(
   parameter int COUNT_BITS = rtt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [2:0]            req_slot,
   input  logic [15:0]           req_start_count,
   input  logic [15:0]           req_reload_count,
   input  logic                  q_full,
   output logic                  q_push,
   output rtt_pkg::cmd_type      q_cmd,
   output logic [COUNT_BITS-1:0] q_start,
   output logic [COUNT_BITS-1:0] q_reload
);

   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   logic        accept;
   logic        known_op;
   logic [32:0] start_ext;
   logic [32:0] reload_ext;

   assign busy   = q_full;
   assign accept = start && !busy;
   assign q_push = accept && known_op;

   // op decode; the unused code is dropped here
   always_comb begin
      known_op      = 1'b1;
      q_cmd.op      = rtt_pkg::CMD_TICK;
      q_cmd.slot    = req_slot;
      case (req_op)
         rtt_pkg::OP_TICK:  q_cmd.op = rtt_pkg::CMD_TICK;
         rtt_pkg::OP_REG:   q_cmd.op = rtt_pkg::CMD_REG;
         rtt_pkg::OP_UNREG: q_cmd.op = rtt_pkg::CMD_UNREG;
         default:           known_op = 1'b0;
      endcase
   end

   // clamp counts to the counter range
   assign start_ext  = 33'(req_start_count);
   assign reload_ext = 33'(req_reload_count);
   assign q_start    = (start_ext > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                               : start_ext[COUNT_BITS-1:0];
   assign q_reload   = (reload_ext > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                : reload_ext[COUNT_BITS-1:0];

endmodule

FILE: rtl/rtt_queue.sv
// short command queue between the front end and the back end
// depends on rtt_pkg for its default depth
module rtt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rtt_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_data = store[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/rtt_exec.sv
// back end: runs tick, register and unregister commands over the slot table
// depends on rtt_pkg; takes commands from rtt_queue, drives the result port
module rtt_exec #(
   parameter int SLOTS      = rtt_pkg::DEFAULT_SLOTS,
   parameter int COUNT_BITS = rtt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  rtt_pkg::cmd_type      q_cmd,
   input  logic [COUNT_BITS-1:0] q_start,
   input  logic [COUNT_BITS-1:0] q_reload,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_kind,
   output logic [2:0]            rsp_slot_index,
   output logic                  rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   rtt_pkg::exec_state_type state_ff, state_in;
   rtt_pkg::cmd_type        cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0]   start_ff, start_in;
   logic [COUNT_BITS-1:0]   reload_ff, reload_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic                    p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]        p_idx_ff, p_idx_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic [SLOTS-1:0]        occ_ff, occ_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [2:0]              rsp_slot_ff, rsp_slot_in;
   logic                    rsp_last_ff, rsp_last_in;

   // count and reload memories, one write and one read port each
   logic [COUNT_BITS-1:0]   rem_mem [SLOTS];
   logic [COUNT_BITS-1:0]   rel_mem [SLOTS];
   logic [COUNT_BITS-1:0]   rem_rd_ff;
   logic [COUNT_BITS-1:0]   rel_rd_ff;
   logic                    rem_we;
   logic                    rel_we;
   logic [IDX_W-1:0]        wr_addr;
   logic [COUNT_BITS-1:0]   rem_wd;
   logic [IDX_W-1:0]        rd_addr;

   logic [IDX_W-1:0]        scan_idx;
   logic [COUNT_BITS-1:0]   rem_dec;
   logic [31:0]             scan_wide;
   logic [31:0]             pend_wide;
   logic [31:0]             unreg_wide;

   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign rem_dec    = rem_rd_ff - COUNT_BITS'(1);
   assign scan_wide  = 32'(scan_idx);
   assign pend_wide  = 32'(pend_idx_ff);
   assign unreg_wide = 32'(cmd_ff.slot);

   // sequencer: next state, table updates and result beats
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      start_in      = start_ff;
      reload_in     = reload_ff;
      scan_in       = scan_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      occ_in        = occ_ff;
      rem_we        = 1'b0;
      rel_we        = 1'b0;
      wr_addr       = scan_idx;
      rem_wd        = start_ff;
      rd_addr       = scan_idx;
      q_pop         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = 1'b0;

      case (state_ff)
         rtt_pkg::EX_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cmd_in        = q_cmd;
               start_in      = q_start;
               reload_in     = q_reload;
               scan_in       = '0;
               pend_valid_in = 1'b0;
               case (q_cmd.op)
                  rtt_pkg::CMD_TICK:  state_in = rtt_pkg::EX_TICK;
                  rtt_pkg::CMD_REG:   state_in = rtt_pkg::EX_REG;
                  rtt_pkg::CMD_UNREG: state_in = rtt_pkg::EX_UNREG;
                  default:            state_in = rtt_pkg::EX_IDLE;
               endcase
            end
         end

         // read slot scan_ff while slot p_idx_ff is updated
         rtt_pkg::EX_TICK: begin
            if (scan_ff != CNT_W'(SLOTS)) begin
               p_valid_in = 1'b1;
               p_idx_in   = scan_idx;
               scan_in    = scan_ff + CNT_W'(1);
            end else begin
               state_in = rtt_pkg::EX_FLUSH;
            end
            if (p_valid_ff && occ_ff[p_idx_ff] && (rem_rd_ff != '0)) begin
               rem_we  = 1'b1;
               wr_addr = p_idx_ff;
               if (rem_dec == '0) begin
                  rem_wd = rel_rd_ff;
                  // an earlier expiry is now known not to be the final one
                  if (pend_valid_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = rtt_pkg::KIND_EXPIRED;
                     rsp_slot_in   = pend_wide[2:0];
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = p_idx_ff;
               end else begin
                  rem_wd = rem_dec;
               end
            end
         end

         // held expiry goes out as the final beat of the tick
         rtt_pkg::EX_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = rtt_pkg::KIND_EXPIRED;
               rsp_slot_in   = pend_wide[2:0];
               rsp_last_in   = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = rtt_pkg::EX_IDLE;
         end

         // look for the lowest free slot, one per cycle
         rtt_pkg::EX_REG: begin
            if (!occ_ff[scan_idx]) begin
               occ_in[scan_idx] = 1'b1;
               rem_we           = 1'b1;
               rel_we           = 1'b1;
               wr_addr          = scan_idx;
               rem_wd           = start_ff;
               rsp_strobe_in    = 1'b1;
               rsp_kind_in      = rtt_pkg::KIND_REGISTERED;
               rsp_slot_in      = scan_wide[2:0];
               rsp_last_in      = 1'b1;
               state_in         = rtt_pkg::EX_IDLE;
            end else if (scan_ff == CNT_W'(SLOTS - 1)) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = rtt_pkg::KIND_FULL;
               rsp_slot_in   = 3'd0;
               rsp_last_in   = 1'b1;
               state_in      = rtt_pkg::EX_IDLE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         rtt_pkg::EX_UNREG: begin
            if (unreg_wide < 32'(SLOTS)) begin
               occ_in[unreg_wide[IDX_W-1:0]] = 1'b0;
            end
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = rtt_pkg::KIND_UNREGISTERED;
            rsp_slot_in   = cmd_ff.slot;
            rsp_last_in   = 1'b1;
            state_in      = rtt_pkg::EX_IDLE;
         end

         default: begin
            state_in = rtt_pkg::EX_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtt_pkg::EX_IDLE;
         p_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         p_valid_ff    <= p_valid_in;
         pend_valid_ff <= pend_valid_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      start_ff    <= start_in;
      reload_ff   <= reload_in;
      scan_ff     <= scan_in;
      p_idx_ff    <= p_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   // count memory
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[wr_addr] <= rem_wd;
      end
      rem_rd_ff <= rem_mem[rd_addr];
   end

   // reload memory
   always_ff @(posedge clock) begin
      if (rel_we) begin
         rel_mem[wr_addr] <= reload_ff;
      end
      rel_rd_ff <= rel_mem[rd_addr];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: rtl/reloading_timer_slot_table.sv
// top level of the reloading timer slot table: front end, queue, back end
// depends on rtt_pkg, rtt_front, rtt_queue and rtt_exec
//
// Usage
//   Request channel: a beat is taken at a rising edge with start high and
//   busy low. req_op selects tick, register or unregister; the unused op
//   code is taken and dropped. busy is high while the two-entry command
//   queue is full.
//   Result channel: each result is on rsp_* for one cycle with rsp_strobe
//   high; rsp_last marks the final result of a request. The receiver cannot
//   stall, and a tick with no expiry gives no result at all.
//   Sequencing: the back end runs one command at a time. Each command
//   first leaves the queue in the idle state. An unregister then clears its
//   slot and gives its result; a register searches for a free slot, looking
//   at one slot per cycle; a tick does one count memory read and update per
//   cycle over all slots, plus a final beat for the held last expiry. A
//   result is on the ports the cycle after the back end produces it.
//   Reset: synchronous; clears the queue, the sequencer and all occupied
//   flags, so every slot is free. Count memories need no clearing since a
//   slot is always loaded when it is marked occupied.
module reloading_timer_slot_table #(
   parameter int SLOTS      = rtt_pkg::DEFAULT_SLOTS,
   parameter int COUNT_BITS = rtt_pkg::DEFAULT_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_start_count,
   input  logic [15:0] req_reload_count,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_last
);

   localparam int Q_WIDTH = $bits(rtt_pkg::cmd_type) + 2 * COUNT_BITS;

   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_not_empty;
   rtt_pkg::cmd_type      f_cmd;
   logic [COUNT_BITS-1:0] f_start;
   logic [COUNT_BITS-1:0] f_reload;
   logic [Q_WIDTH-1:0]    q_head;
   rtt_pkg::cmd_type      b_cmd;
   logic [COUNT_BITS-1:0] b_start;
   logic [COUNT_BITS-1:0] b_reload;

   // decode and clamp incoming beats
   rtt_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_start_count  (req_start_count),
      .req_reload_count (req_reload_count),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (f_cmd),
      .q_start          (f_start),
      .q_reload         (f_reload)
   );

   // command queue
   rtt_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (rtt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_cmd, f_start, f_reload}),
      .pop       (q_pop),
      .head_data (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   assign {b_cmd, b_start, b_reload} = q_head;

   // slot table sequencer
   rtt_exec #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_exec (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_cmd          (b_cmd),
      .q_start        (b_start),
      .q_reload       (b_reload),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_slot_index (rsp_slot_index),
      .rsp_last       (rsp_last)
   );

   // only expiries can be followed by another beat of the same request
   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != rtt_pkg::KIND_EXPIRED) |-> rsp_last)
      else $error("non-expiry result without last");

   // a full table reports slot zero
   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == rtt_pkg::KIND_FULL) |-> (rsp_slot_index == 3'd0))
      else $error("full result with nonzero slot");

   // not busy and no result right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_strobe))
      else $error("busy or result right after reset");

endmodule

FILE: dv/reloading_timer_slot_table_test.sv
// testbench for the reloading timer slot table: directed and random request beats
// depends on rtt_pkg and reloading_timer_slot_table; results checked against a local predictor
`timescale 1ns / 100ps

module reloading_timer_slot_table_test;

   localparam int SLOTS = rtt_pkg::DEFAULT_SLOTS;
   localparam int DRAIN_CYCLES = SLOTS + 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct {
      logic [1:0] kind;
      logic [2:0] slot_index;
      logic       last;
   } timer_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = rtt_pkg::OP_TICK;
   logic [2:0]  req_slot = 3'd0;
   logic [15:0] req_start_count = 16'd0;
   logic [15:0] req_reload_count = 16'd0;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_slot_index;
   logic        rsp_last;

   // predicted slot table
   logic        slot_taken [SLOTS];
   logic [15:0] ticks_left [SLOTS];
   logic [15:0] reload_ticks [SLOTS];

   timer_event_type pending_events [$];

   int cycle_count = 0;
   int mismatches = 0;
   int events_checked = 0;
   int expiries_checked = 0;
   int op_counts [4] = '{0, 0, 0, 0};

   reloading_timer_slot_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_start_count  (req_start_count),
      .req_reload_count (req_reload_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_last         (rsp_last)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events still pending",
                  cycle_count, pending_events.size());
         $display("FAIL");
         $finish;
      end
   end

   // update the slot table for one accepted beat and queue the events it causes
   task automatic predict_events(input logic [1:0] op, input logic [2:0] slot,
                                 input logic [15:0] start_cnt, input logic [15:0] reload_cnt);
      timer_event_type fresh [$];
      timer_event_type ev;
      int found;
      found = -1;
      case (op)
         rtt_pkg::OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_taken[i] && ticks_left[i] != 16'd0) begin
                  ticks_left[i] = ticks_left[i] - 16'd1;
                  if (ticks_left[i] == 16'd0) begin
                     ev = '{rtt_pkg::KIND_EXPIRED, i[2:0], 1'b0};
                     fresh.push_back(ev);
                     ticks_left[i] = reload_ticks[i];
                  end
               end
            end
         end
         rtt_pkg::OP_REG: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (found < 0 && !slot_taken[i]) found = i;
            end
            if (found >= 0) begin
               slot_taken[found] = 1'b1;
               ticks_left[found] = start_cnt;
               reload_ticks[found] = reload_cnt;
               ev = '{rtt_pkg::KIND_REGISTERED, found[2:0], 1'b1};
            end else begin
               ev = '{rtt_pkg::KIND_FULL, 3'd0, 1'b1};
            end
            fresh.push_back(ev);
         end
         rtt_pkg::OP_UNREG: begin
            slot_taken[slot] = 1'b0;
            ev = '{rtt_pkg::KIND_UNREGISTERED, slot, 1'b1};
            fresh.push_back(ev);
         end
         default: ;
      endcase
      // final event of the beat carries last
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[k]) pending_events.push_back(fresh[k]);
   endtask

   // offer one request beat, wait for it to be taken, then maybe idle
   task automatic send_beat(input logic [1:0] op, input logic [2:0] slot,
                            input logic [15:0] start_cnt, input logic [15:0] reload_cnt,
                            input int idle_pct);
      start <= 1'b1;
      req_op <= op;
      req_slot <= slot;
      req_start_count <= start_cnt;
      req_reload_count <= reload_cnt;
      do @(posedge clock); while (busy !== 1'b0);
      predict_events(op, slot, start_cnt, reload_cnt);
      op_counts[op]++;
      // idle whole cycles, each with the given chance
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // check every result beat against the oldest pending event
   always @(posedge clock) begin : event_check
      timer_event_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_events.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: kind %0d slot %0d last %0d",
                        rsp_kind, rsp_slot_index, rsp_last);
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_kind !== want.kind || rsp_slot_index !== want.slot_index ||
                rsp_last !== want.last) begin
               if (mismatches < 10)
                  $display("result %0d: expected kind %0d slot %0d last %0d, got %0d %0d %0d",
                           events_checked, want.kind, want.slot_index, want.last,
                           rsp_kind, rsp_slot_index, rsp_last);
               mismatches++;
            end
            if (want.kind == rtt_pkg::KIND_EXPIRED) expiries_checked++;
            events_checked++;
         end
      end
   end

   // mostly small counts so timers expire often, sometimes the full range
   function automatic logic [15:0] random_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return 16'($urandom_range(0, 5));
      if (roll < 88) return 16'($urandom_range(0, 300));
      return 16'($urandom_range(0, 65535));
   endfunction

   // fill the table, odd slots periodic with reload 2, even slots one-shot; then overflow
   task automatic test_register_full();
      for (int i = 0; i < SLOTS; i++)
         send_beat(rtt_pkg::OP_REG, ~i[2:0], 16'd1, (i % 2 == 1) ? 16'd2 : 16'd0, 0);
      send_beat(rtt_pkg::OP_REG, 3'd7, COUNT_MAX, COUNT_MAX, 0);
   endtask

   // all slots expire at once, then a tick with no expiry, then only periodic ones
   task automatic test_tick_expiry();
      send_beat(rtt_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, 0);
      send_beat(rtt_pkg::OP_TICK, 3'd7, COUNT_MAX, COUNT_MAX, 0);
      send_beat(rtt_pkg::OP_TICK, 3'd5, 16'd0, COUNT_MAX, 0);
   endtask

   // free a taken and a free slot, inactive register, extreme counts
   task automatic test_unregister();
      send_beat(rtt_pkg::OP_UNREG, 3'd0, COUNT_MAX, COUNT_MAX, 0);
      send_beat(rtt_pkg::OP_UNREG, 3'd0, 16'd0, 16'd0, 0);
      send_beat(rtt_pkg::OP_REG, 3'd3, 16'd0, COUNT_MAX, 0);
      send_beat(rtt_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, 0);
      send_beat(rtt_pkg::OP_UNREG, 3'd7, 16'd0, 16'd0, 0);
      send_beat(rtt_pkg::OP_REG, 3'd0, COUNT_MAX, COUNT_MAX, 0);
   endtask

   // unused op code is dropped without result or state change
   task automatic test_ignored_op();
      send_beat(OP_UNUSED, 3'd7, COUNT_MAX, COUNT_MAX, 0);
      send_beat(OP_UNUSED, 3'd0, 16'd0, 16'd0, 0);
      send_beat(rtt_pkg::OP_TICK, 3'd2, 16'd0, 16'd0, 0);
   endtask

   // random mix weighted toward live timers; ignored beats do not count
   task automatic test_random_traffic(input int idle_pct, input int beats);
      int done;
      int pick;
      int taken_n;
      logic [1:0] op;
      logic [2:0] target;
      done = 0;
      while (done < beats) begin
         taken_n = 0;
         for (int i = 0; i < SLOTS; i++) if (slot_taken[i]) taken_n++;
         pick = $urandom_range(99);
         if (pick < 3) op = OP_UNUSED;
         else if (pick < 48) op = rtt_pkg::OP_TICK;
         else if (pick < ((taken_n == SLOTS) ? 60 : 78)) op = rtt_pkg::OP_REG;
         else op = rtt_pkg::OP_UNREG;
         target = 3'($urandom_range(7));
         if (op == rtt_pkg::OP_UNREG && taken_n > 0 && $urandom_range(99) < 80) begin
            do target = 3'($urandom_range(SLOTS - 1)); while (!slot_taken[target]);
         end
         send_beat(op, target, random_count(), random_count(), idle_pct);
         if (op != OP_UNUSED) done++;
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_taken[i] = 1'b0;
         ticks_left[i] = 16'd0;
         reload_ticks[i] = 16'd0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_register_full();
      test_tick_expiry();
      test_unregister();
      test_ignored_op();
      test_random_traffic(38, 100);
      test_random_traffic(86, 100);
      test_random_traffic(0, 100);
      start <= 1'b0;

      // drain, then watch for stray results
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d ticks, %0d registers, %0d unregisters, %0d unused-op beats",
               op_counts[rtt_pkg::OP_TICK], op_counts[rtt_pkg::OP_REG],
               op_counts[rtt_pkg::OP_UNREG], op_counts[OP_UNUSED]);
      $display("checked %0d results including %0d expiries, %0d mismatches",
               events_checked, expiries_checked, mismatches);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: reloading_timer_slot_table.f
rtl/rtt_pkg.sv
rtl/rtt_front.sv
rtl/rtt_queue.sv
rtl/rtt_exec.sv
rtl/reloading_timer_slot_table.sv
dv/reloading_timer_slot_table_test.sv
